[rtl/author_topic_gibbs_sampler_unit_macros.svh]
// Assertion helpers shared by the sampler's top level.
`ifndef AUTHOR_TOPIC_GIBBS_SAMPLER_UNIT_MACROS_SVH
`define AUTHOR_TOPIC_GIBBS_SAMPLER_UNIT_MACROS_SVH

`define ATGS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ATGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/atgs_pkg.sv]
`default_nettype none
package atgs_pkg;

	localparam int DEF_MAX_TOPICS          = 64;
	localparam int DEF_MAX_AUTHORS_PER_DOC = 8;
	localparam int DEF_MAX_DOCS            = 1024;
	localparam int DEF_MAX_AUTHORS         = 1024;
	localparam int DEF_MAX_WORDS           = 16384;

	localparam logic [1:0] ACT_LOAD_SLOT = 2'd0;
	localparam logic [1:0] ACT_ADD_TOKEN = 2'd1;
	localparam logic [1:0] ACT_RESAMPLE  = 2'd2;
	localparam logic [1:0] ACT_LOAD_WORD = 2'd3;

	localparam logic [2:0] CFG_ALPHA      = 3'd0;
	localparam logic [2:0] CFG_BETA       = 3'd1;
	localparam logic [2:0] CFG_NUM_TOPICS = 3'd2;
	localparam logic [2:0] CFG_VOCAB_SIZE = 3'd3;
	localparam logic [2:0] CFG_FIXED_WORD = 3'd4;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DECODE, ST_REM_RD, ST_REM_WR, ST_SLOT_RD, ST_CNT_RD,
		ST_DIV_START, ST_DIV_WAIT, ST_QMUL, ST_QSAT, ST_IMUL, ST_ACC, ST_THR,
		ST_THR_SET, ST_SRCH_RD, ST_SRCH_CMP, ST_SEL_RD, ST_SEL_SET, ST_FAIL,
		ST_ADD_RD, ST_ADD_WR, ST_LD_RD, ST_LD_WR, ST_FINISH
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_DECODE, OP_PAIR_RD, OP_PAIR_SUB, OP_PAIR_ADD,
		OP_CNT_RD, OP_DIV_START, OP_QMUL, OP_QSAT, OP_IMUL, OP_ACC, OP_THR,
		OP_THR_SET, OP_SRCH_CMP, OP_SEL_SET, OP_FAIL, OP_LD_WR
	} op_t;

	typedef struct packed {
		op_t  op;
		logic accept;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       clear_done;
		logic       bad;
		logic [1:0] action;
		logic       div_done;
		logic       mul_last;
		logic       l_last;
		logic       slot_last;
		logic       no_auth;
		logic       found;
	} sts_t;

	function automatic int aw(input int d);
		return (d > 1) ? $clog2(d) : 1;
	endfunction

endpackage
`default_nettype wire

[rtl/atgs_div.sv]
`default_nettype none
module atgs_div
	import atgs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic      [63:0] quot,
	output logic             done
);

	logic [63:0] n_q, d_q, rem_q, q_q;
	logic        over_q, busy_q, done_q;
	logic [6:0]  cnt_q;
	logic [64:0] r65;
	logic        ge;

	assign r65  = {rem_q, (cnt_q < 7'd64) ? n_q[63] : 1'b0};
	assign ge   = r65 >= {1'b0, d_q};
	assign quot = over_q ? '1 : q_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 7'd1;
			if (cnt_q == 7'd95) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= num;
			d_q    <= den;
			rem_q  <= '0;
			q_q    <= '0;
			over_q <= 1'b0;
		end else if (busy_q) begin
			n_q    <= {n_q[62:0], 1'b0};
			rem_q  <= ge ? 64'(r65 - {1'b0, d_q}) : r65[63:0];
			over_q <= over_q | q_q[63];
			q_q    <= {q_q[62:0], ge};
		end
	end

endmodule
`default_nettype wire

[rtl/atgs_ctrl.sv]
`default_nettype none
module atgs_ctrl
	import atgs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (sts.clear_done) state_d = ST_IDLE;
			ST_IDLE:      if (in_valid) state_d = ST_DECODE;
			ST_DECODE: begin
				if (sts.bad) begin
					state_d = ST_FINISH;
				end else begin
					unique case (sts.action)
						ACT_LOAD_SLOT: state_d = ST_FINISH;
						ACT_ADD_TOKEN: state_d = ST_ADD_RD;
						ACT_RESAMPLE:  state_d = ST_REM_RD;
						ACT_LOAD_WORD: state_d = ST_LD_RD;
						default:       state_d = ST_FINISH;
					endcase
				end
			end
			ST_REM_RD:    state_d = ST_REM_WR;
			ST_REM_WR:    state_d = sts.no_auth ? ST_FAIL : ST_SLOT_RD;
			ST_SLOT_RD:   state_d = ST_CNT_RD;
			ST_CNT_RD:    state_d = ST_DIV_START;
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT:  if (sts.div_done) state_d = ST_QMUL;
			ST_QMUL:      if (sts.mul_last) state_d = ST_QSAT;
			ST_QSAT:      state_d = ST_IMUL;
			ST_IMUL:      if (sts.mul_last) state_d = ST_ACC;
			ST_ACC: begin
				priority if (sts.l_last && sts.slot_last) state_d = ST_THR;
				else if (sts.l_last) state_d = ST_SLOT_RD;
				else state_d = ST_CNT_RD;
			end
			ST_THR:       if (sts.mul_last) state_d = ST_THR_SET;
			ST_THR_SET:   state_d = ST_SRCH_RD;
			ST_SRCH_RD:   state_d = ST_SRCH_CMP;
			ST_SRCH_CMP: begin
				priority if (sts.found) state_d = ST_SEL_RD;
				else if (sts.l_last && sts.slot_last) state_d = ST_FAIL;
				else state_d = ST_SRCH_RD;
			end
			ST_SEL_RD:    state_d = ST_SEL_SET;
			ST_SEL_SET:   state_d = ST_ADD_RD;
			ST_FAIL:      state_d = ST_ADD_RD;
			ST_ADD_RD:    state_d = ST_ADD_WR;
			ST_ADD_WR:    state_d = ST_FINISH;
			ST_LD_RD:     state_d = ST_LD_WR;
			ST_LD_WR:     state_d = ST_FINISH;
			ST_FINISH:    if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.out_load = (state_q == ST_FINISH) && out_free;
		unique case (state_q)
			ST_CLEAR:     cmd.op = OP_CLEAR;
			ST_DECODE:    cmd.op = OP_DECODE;
			ST_REM_RD:    cmd.op = OP_PAIR_RD;
			ST_REM_WR:    cmd.op = OP_PAIR_SUB;
			ST_CNT_RD:    cmd.op = OP_CNT_RD;
			ST_DIV_START: cmd.op = OP_DIV_START;
			ST_QMUL:      cmd.op = OP_QMUL;
			ST_QSAT:      cmd.op = OP_QSAT;
			ST_IMUL:      cmd.op = OP_IMUL;
			ST_ACC:       cmd.op = OP_ACC;
			ST_THR:       cmd.op = OP_THR;
			ST_THR_SET:   cmd.op = OP_THR_SET;
			ST_SRCH_CMP:  cmd.op = OP_SRCH_CMP;
			ST_SEL_SET:   cmd.op = OP_SEL_SET;
			ST_FAIL:      cmd.op = OP_FAIL;
			ST_ADD_RD:    cmd.op = OP_PAIR_RD;
			ST_ADD_WR:    cmd.op = OP_PAIR_ADD;
			ST_LD_RD:     cmd.op = OP_PAIR_RD;
			ST_LD_WR:     cmd.op = OP_LD_WR;
			default:      cmd.op = OP_NONE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/atgs_dp.sv]
`default_nettype none
module atgs_dp
	import atgs_pkg::*;
#(
	parameter int MAX_TOPICS          = DEF_MAX_TOPICS,
	parameter int MAX_AUTHORS_PER_DOC = DEF_MAX_AUTHORS_PER_DOC,
	parameter int MAX_DOCS            = DEF_MAX_DOCS,
	parameter int MAX_AUTHORS         = DEF_MAX_AUTHORS,
	parameter int MAX_WORDS           = DEF_MAX_WORDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	input  wire logic [1:0]  action,
	input  wire logic [9:0]  doc,
	input  wire logic [2:0]  slot,
	input  wire logic [3:0]  slot_count,
	input  wire logic [9:0]  author,
	input  wire logic [15:0] weight,
	input  wire logic [13:0] word,
	input  wire logic [5:0]  topic,
	input  wire logic [30:0] count_value,
	input  wire logic [31:0] random_fraction,
	output logic      [9:0]  new_author,
	output logic      [5:0]  new_topic,
	output logic             status
);

	localparam int KCAP   = (MAX_TOPICS < 64) ? MAX_TOPICS : 64;
	localparam int AT_D   = MAX_AUTHORS * MAX_TOPICS;
	localparam int WT_D   = MAX_WORDS * MAX_TOPICS;
	localparam int DA_D   = MAX_DOCS * MAX_AUTHORS_PER_DOC;
	localparam int CUM_D  = MAX_AUTHORS_PER_DOC * KCAP;
	localparam int CLR_A  = (AT_D > WT_D) ? AT_D : WT_D;
	localparam int CLR_B  = (MAX_AUTHORS > MAX_DOCS) ? MAX_AUTHORS : MAX_DOCS;
	localparam int CLR_C  = (CLR_B > MAX_TOPICS) ? CLR_B : MAX_TOPICS;
	localparam int CLR_N  = (CLR_A > CLR_C) ? CLR_A : CLR_C;
	localparam int CLR_W  = $clog2(CLR_N + 1);
	localparam int AT_AW  = aw(AT_D);
	localparam int WT_AW  = aw(WT_D);
	localparam int DA_AW  = aw(DA_D);
	localparam int CUM_AW = aw(CUM_D);
	localparam int AU_AW  = aw(MAX_AUTHORS);
	localparam int TP_AW  = aw(MAX_TOPICS);
	localparam int DC_AW  = aw(MAX_DOCS);
	localparam int SW     = aw(MAX_AUTHORS_PER_DOC);
	localparam int CNTW   = $clog2(MAX_AUTHORS_PER_DOC + 1);

	logic [23:0] alpha_q, beta_q;
	logic [6:0]  num_topics_q;
	logic [14:0] vocab_q;
	logic        fixed_q;

	logic [1:0]  act_q;
	logic [9:0]  doc_q, author_q;
	logic [2:0]  slot_q;
	logic [3:0]  scnt_q;
	logic [15:0] weight_q;
	logic [13:0] word_q;
	logic [5:0]  topic_q;
	logic [30:0] cval_q;
	logic [31:0] rnd_q;

	logic [9:0]  pa_q;
	logic [5:0]  pt_q;
	logic [9:0]  res_a_q;
	logic [5:0]  res_t_q;
	logic        res_st_q;

	logic [CLR_W-1:0] clr_q;
	logic [SW-1:0]    ai_q;
	logic [5:0]       l_q;
	logic [2:0]       mstep_q;
	logic [30:0]      kalpha_q;
	logic [38:0]      vbeta_q;
	logic [63:0]      run_q, thr_q, qres_q;
	logic             zd_q;
	logic [63:0]      prod_s1;
	logic [1:0]       sh_s1;
	logic [127:0]     acc_q;

	logic [31:0]     at_mem   [AT_D];
	logic [31:0]     atot_mem [MAX_AUTHORS];
	logic [31:0]     wt_mem   [WT_D];
	logic [31:0]     tt_mem   [MAX_TOPICS];
	logic [CNTW-1:0] dcnt_mem [MAX_DOCS];
	logic [9:0]      did_mem  [DA_D];
	logic [15:0]     dw_mem   [DA_D];
	logic [63:0]     cum_mem  [CUM_D];

	logic [31:0]     at_rd_q, atot_rd_q, wt_rd_q, tt_rd_q;
	logic [CNTW-1:0] dcnt_rd_q;
	logic [9:0]      did_rd_q;
	logic [15:0]     dw_rd_q;
	logic [63:0]     cum_rd_q;

	logic        clearing, pair_wr, pair_add, ld_wr, slot_wr;
	logic        ok0, ok1, ok2, ok3, bad;
	logic [6:0]  kc;
	logic [9:0]  acur, asel;
	logic [31:0] pair_at, cnt_at, pair_wt, cnt_wt, da_addr, cum_addr;
	logic [31:0] at_next, atot_next, wt_next, tt_next, tt_load;
	logic [63:0] num_a, den_a, num_w, den_w, qa, qb, wgt, run_sum;
	logic        done_a, done_b, mul_op, l_last, slot_last;
	logic [2:0]  mul_n;
	logic [31:0] mul_a, mul_b;
	logic [1:0]  mul_sh;
	logic [32:0] tt_sum;

	function automatic logic [31:0] inc_sat(input logic [31:0] x);
		return (x == '1) ? x : x + 32'd1;
	endfunction

	function automatic logic [31:0] dec_sat(input logic [31:0] x);
		return (x == '0) ? x : x - 32'd1;
	endfunction

	assign kc = (num_topics_q == 7'd0) ? 7'd1 :
		((32'(num_topics_q) > KCAP) ? 7'(KCAP) : num_topics_q);

	assign ok0 = (32'(doc_q) < MAX_DOCS) && (32'(slot_q) < MAX_AUTHORS_PER_DOC) &&
		(32'(author_q) < MAX_AUTHORS);
	assign ok1 = (32'(author_q) < MAX_AUTHORS) && (32'(topic_q) < MAX_TOPICS) &&
		(32'(word_q) < MAX_WORDS);
	assign ok2 = ok1 && (32'(doc_q) < MAX_DOCS);
	assign ok3 = (32'(word_q) < MAX_WORDS) && (32'(topic_q) < MAX_TOPICS);

	always_comb begin
		unique case (act_q)
			ACT_LOAD_SLOT: bad = !ok0;
			ACT_ADD_TOKEN: bad = !ok1;
			ACT_RESAMPLE:  bad = !ok2;
			ACT_LOAD_WORD: bad = !ok3;
			default:       bad = 1'b1;
		endcase
	end

	assign acur     = (32'(did_rd_q) < MAX_AUTHORS) ? did_rd_q : 10'd0;
	assign asel     = acur;
	assign pair_at  = 32'(pa_q) * 32'(MAX_TOPICS) + 32'(pt_q);
	assign cnt_at   = 32'(acur) * 32'(MAX_TOPICS) + 32'(l_q);
	assign pair_wt  = 32'(word_q) * 32'(MAX_TOPICS) + 32'(pt_q);
	assign cnt_wt   = 32'(word_q) * 32'(MAX_TOPICS) + 32'(l_q);
	assign da_addr  = 32'(doc_q) * 32'(MAX_AUTHORS_PER_DOC) + 32'(ai_q);
	assign cum_addr = 32'(ai_q) * 32'(KCAP) + 32'(l_q);

	assign clearing = (cmd.op == OP_CLEAR) && (32'(clr_q) < CLR_N);
	assign pair_add = cmd.op == OP_PAIR_ADD;
	assign pair_wr  = pair_add || (cmd.op == OP_PAIR_SUB);
	assign ld_wr    = cmd.op == OP_LD_WR;
	assign slot_wr  = (cmd.op == OP_DECODE) && (act_q == ACT_LOAD_SLOT) && !bad;

	assign at_next   = pair_add ? inc_sat(at_rd_q) : dec_sat(at_rd_q);
	assign atot_next = pair_add ? inc_sat(atot_rd_q) : dec_sat(atot_rd_q);
	assign wt_next   = pair_add ? inc_sat(wt_rd_q) : dec_sat(wt_rd_q);
	assign tt_next   = pair_add ? inc_sat(tt_rd_q) : dec_sat(tt_rd_q);
	assign tt_sum    = {1'b0, tt_rd_q} + {2'b0, cval_q};
	assign tt_load   = tt_sum[32] ? '1 : tt_sum[31:0];

	always_ff @(posedge clk) begin
		if (clearing && (32'(clr_q) < AT_D)) begin
			at_mem[AT_AW'(clr_q)] <= '0;
		end else if (pair_wr) begin
			at_mem[AT_AW'(pair_at)] <= at_next;
		end
		at_rd_q <= at_mem[AT_AW'((cmd.op == OP_CNT_RD) ? cnt_at : pair_at)];
	end

	always_ff @(posedge clk) begin
		if (clearing && (32'(clr_q) < MAX_AUTHORS)) begin
			atot_mem[AU_AW'(clr_q)] <= '0;
		end else if (pair_wr) begin
			atot_mem[AU_AW'(pa_q)] <= atot_next;
		end
		atot_rd_q <= atot_mem[AU_AW'((cmd.op == OP_CNT_RD) ? acur : pa_q)];
	end

	always_ff @(posedge clk) begin
		if (clearing && (32'(clr_q) < WT_D)) begin
			wt_mem[WT_AW'(clr_q)] <= '0;
		end else if (ld_wr) begin
			wt_mem[WT_AW'(pair_wt)] <= {1'b0, cval_q};
		end else if (pair_wr && !fixed_q) begin
			wt_mem[WT_AW'(pair_wt)] <= wt_next;
		end
		wt_rd_q <= wt_mem[WT_AW'((cmd.op == OP_CNT_RD) ? cnt_wt : pair_wt)];
	end

	always_ff @(posedge clk) begin
		if (clearing && (32'(clr_q) < MAX_TOPICS)) begin
			tt_mem[TP_AW'(clr_q)] <= '0;
		end else if (ld_wr) begin
			tt_mem[TP_AW'(pt_q)] <= tt_load;
		end else if (pair_wr && !fixed_q) begin
			tt_mem[TP_AW'(pt_q)] <= tt_next;
		end
		tt_rd_q <= tt_mem[TP_AW'((cmd.op == OP_CNT_RD) ? l_q : pt_q)];
	end

	always_ff @(posedge clk) begin
		if (clearing && (32'(clr_q) < MAX_DOCS)) begin
			dcnt_mem[DC_AW'(clr_q)] <= '0;
		end else if (slot_wr) begin
			dcnt_mem[DC_AW'(doc_q)] <= (32'(scnt_q) > MAX_AUTHORS_PER_DOC) ?
				CNTW'(MAX_AUTHORS_PER_DOC) : CNTW'(scnt_q);
		end
		dcnt_rd_q <= dcnt_mem[DC_AW'(doc_q)];
	end

	always_ff @(posedge clk) begin
		if (slot_wr) begin
			did_mem[DA_AW'(32'(doc_q) * 32'(MAX_AUTHORS_PER_DOC) + 32'(slot_q))] <= author_q;
			dw_mem[DA_AW'(32'(doc_q) * 32'(MAX_AUTHORS_PER_DOC) + 32'(slot_q))]  <= weight_q;
		end
		did_rd_q <= did_mem[DA_AW'(da_addr)];
		dw_rd_q  <= dw_mem[DA_AW'(da_addr)];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACC) begin
			cum_mem[CUM_AW'(cum_addr)] <= run_sum;
		end
		cum_rd_q <= cum_mem[CUM_AW'(cum_addr)];
	end

	assign num_a = {16'b0, at_rd_q, 16'b0} + 64'(alpha_q);
	assign den_a = {16'b0, atot_rd_q, 16'b0} + 64'(kalpha_q);
	assign num_w = {16'b0, wt_rd_q, 16'b0} + 64'(beta_q);
	assign den_w = {16'b0, tt_rd_q, 16'b0} + 64'(vbeta_q);

	atgs_div u_div_a (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_START),
		.num    (num_a),
		.den    (den_a),
		.quot   (qa),
		.done   (done_a)
	);

	atgs_div u_div_w (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_DIV_START),
		.num    (num_w),
		.den    (den_w),
		.quot   (qb),
		.done   (done_b)
	);

	assign mul_op = (cmd.op == OP_QMUL) || (cmd.op == OP_IMUL) || (cmd.op == OP_THR);
	assign mul_n  = (cmd.op == OP_QMUL) ? 3'd4 : 3'd2;

	always_comb begin
		mul_a  = qa[31:0];
		mul_b  = qb[31:0];
		mul_sh = 2'd0;
		unique case (cmd.op)
			OP_QMUL: begin
				mul_a  = mstep_q[1] ? qa[63:32] : qa[31:0];
				mul_b  = mstep_q[0] ? qb[63:32] : qb[31:0];
				mul_sh = (mstep_q == 3'd0) ? 2'd0 : ((mstep_q == 3'd3) ? 2'd2 : 2'd1);
			end
			OP_IMUL: begin
				mul_a  = mstep_q[0] ? qres_q[63:32] : qres_q[31:0];
				mul_b  = {16'b0, dw_rd_q};
				mul_sh = {1'b0, mstep_q[0]};
			end
			OP_THR: begin
				mul_a  = mstep_q[0] ? run_q[63:32] : run_q[31:0];
				mul_b  = rnd_q;
				mul_sh = {1'b0, mstep_q[0]};
			end
			default: begin
				mul_a  = qa[31:0];
				mul_b  = qb[31:0];
				mul_sh = 2'd0;
			end
		endcase
	end

	assign wgt     = zd_q ? 64'd0 : ((acc_q[127:64] != '0) ? '1 : acc_q[63:0]);
	assign run_sum = ((run_q + wgt) < run_q) ? '1 : run_q + wgt;

	assign l_last    = (7'(l_q) + 7'd1) == kc;
	assign slot_last = (32'(ai_q) + 32'd1) == 32'(dcnt_rd_q);

	always_ff @(posedge clk) begin
		prod_s1 <= 64'(mul_a) * 64'(mul_b);
		sh_s1   <= mul_sh;
		if (mul_op && (mstep_q != 3'd0)) begin
			acc_q <= ((mstep_q == 3'd1) ? 128'd0 : acc_q) +
				({64'd0, prod_s1} << (7'(sh_s1) * 7'd32));
		end
		unique case (cmd.op)
			OP_DECODE: begin
				kalpha_q <= 31'(kc * alpha_q);
				vbeta_q  <= 39'(vocab_q * beta_q);
				run_q    <= '0;
			end
			OP_DIV_START: zd_q   <= (den_a == '0) || (den_w == '0);
			OP_QSAT:      qres_q <= (acc_q[127:96] != '0) ? '1 : acc_q[95:32];
			OP_ACC:       run_q  <= run_sum;
			OP_THR_SET:   thr_q  <= acc_q[95:32];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q    <= action;
			doc_q    <= doc;
			slot_q   <= slot;
			scnt_q   <= slot_count;
			author_q <= author;
			weight_q <= weight;
			word_q   <= word;
			topic_q  <= topic;
			cval_q   <= count_value;
			rnd_q    <= random_fraction;
			pa_q     <= author;
			pt_q     <= topic;
			res_a_q  <= author;
			res_t_q  <= topic;
		end else if (cmd.op == OP_SEL_SET) begin
			pa_q    <= asel;
			pt_q    <= l_q;
			res_a_q <= asel;
			res_t_q <= l_q;
		end else if (cmd.op == OP_FAIL) begin
			pa_q <= author_q;
			pt_q <= topic_q;
		end
		if (cmd.out_load) begin
			new_author <= res_a_q;
			new_topic  <= res_t_q;
			status     <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= 24'd32768;
			beta_q       <= 24'd655;
			num_topics_q <= 7'd64;
			vocab_q      <= 15'd16384;
			fixed_q      <= 1'b0;
			clr_q        <= '0;
			ai_q         <= '0;
			l_q          <= '0;
			mstep_q      <= '0;
			res_st_q     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_ALPHA:      alpha_q      <= cfg_data;
					CFG_BETA:       beta_q       <= cfg_data;
					CFG_NUM_TOPICS: num_topics_q <= cfg_data[6:0];
					CFG_VOCAB_SIZE: vocab_q      <= cfg_data[14:0];
					CFG_FIXED_WORD: fixed_q      <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (clearing) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			mstep_q <= (mul_op && (mstep_q != mul_n)) ? mstep_q + 3'd1 : 3'd0;
			priority if ((cmd.op == OP_DECODE) || (cmd.op == OP_THR_SET)) begin
				ai_q <= '0;
				l_q  <= '0;
			end else if ((cmd.op == OP_ACC) ||
				((cmd.op == OP_SRCH_CMP) && !(cum_rd_q > thr_q))) begin
				if (l_last) begin
					l_q  <= '0;
					ai_q <= ai_q + SW'(1);
				end else begin
					l_q <= l_q + 6'd1;
				end
			end
			if (cmd.op == OP_DECODE) begin
				res_st_q <= (act_q == ACT_RESAMPLE) && bad;
			end else if (cmd.op == OP_FAIL) begin
				res_st_q <= 1'b1;
			end
		end
	end

	assign sts.clear_done = 32'(clr_q) == CLR_N;
	assign sts.bad        = bad;
	assign sts.action     = act_q;
	assign sts.div_done   = done_a && done_b;
	assign sts.mul_last   = mstep_q == mul_n;
	assign sts.l_last     = l_last;
	assign sts.slot_last  = slot_last;
	assign sts.no_auth    = dcnt_rd_q == '0;
	assign sts.found      = cum_rd_q > thr_q;

endmodule
`default_nettype wire

[rtl/author_topic_gibbs_sampler_unit.sv]
// A resample works out one weight per document author and topic, each with the
// bit-serial divider pair and the shared 32x32 multiplier.
// One word is in flight at a time; the result waits in an output register.
// After reset a clearing pass zeroes the count tables before the first word
// is accepted.
`default_nettype none
`include "author_topic_gibbs_sampler_unit_macros.svh"
module author_topic_gibbs_sampler_unit
	import atgs_pkg::*;
#(
	parameter int MAX_TOPICS          = DEF_MAX_TOPICS,
	parameter int MAX_AUTHORS_PER_DOC = DEF_MAX_AUTHORS_PER_DOC,
	parameter int MAX_DOCS            = DEF_MAX_DOCS,
	parameter int MAX_AUTHORS         = DEF_MAX_AUTHORS,
	parameter int MAX_WORDS           = DEF_MAX_WORDS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wen,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// doc, slot, slot_count, author, weight, word, topic, count_value,
	// random_fraction, then zero padding.
	input  wire logic [127:0] s_axis_tdata,
	// action.
	input  wire logic [1:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// new_author, new_topic.
	output logic      [15:0]  m_axis_tdata,
	// status.
	output logic      [0:0]   m_axis_tuser
);

	cmd_t cmd;
	sts_t sts;

	atgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	atgs_dp #(
		.MAX_TOPICS          (MAX_TOPICS),
		.MAX_AUTHORS_PER_DOC (MAX_AUTHORS_PER_DOC),
		.MAX_DOCS            (MAX_DOCS),
		.MAX_AUTHORS         (MAX_AUTHORS),
		.MAX_WORDS           (MAX_WORDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.action          (s_axis_tuser),
		.doc             (s_axis_tdata[9:0]),
		.slot            (s_axis_tdata[12:10]),
		.slot_count      (s_axis_tdata[16:13]),
		.author          (s_axis_tdata[26:17]),
		.weight          (s_axis_tdata[42:27]),
		.word            (s_axis_tdata[56:43]),
		.topic           (s_axis_tdata[62:57]),
		.count_value     (s_axis_tdata[93:63]),
		.random_fraction (s_axis_tdata[125:94]),
		.new_author      (m_axis_tdata[9:0]),
		.new_topic       (m_axis_tdata[15:10]),
		.status          (m_axis_tuser[0])
	);

	`ATGS_ASSERT_SAME(a_no_accept_while_clearing, s_axis_tvalid && s_axis_tready, sts.clear_done, "word accepted during clearing pass")
	`ATGS_ASSERT_NEXT(a_one_word_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second word accepted while one is in flight")
	`ATGS_ASSERT_SAME(a_out_reg_free, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwrote a word not yet taken")

endmodule
`default_nettype wire

[bench/tb_author_topic_gibbs_sampler_unit.sv]
`default_nettype none
module tb_author_topic_gibbs_sampler_unit;
	import atgs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		logic [1:0] action;
		bit [9:0]   doc;
		bit [2:0]   slot;
		bit [3:0]   slot_count;
		bit [9:0]   author;
		bit [15:0]  weight;
		bit [13:0]  word;
		bit [5:0]   topic;
		bit [30:0]  count_value;
		bit [31:0]  random_fraction;
	} token_word_t;

	typedef struct {
		bit [9:0] author;
		bit [5:0] topic;
		bit       status;
	} assignment_t;

	typedef struct {
		bit [9:0]  doc;
		bit [9:0]  author;
		bit [5:0]  topic;
		bit [13:0] word;
	} token_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wen = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [23:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [15:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	author_topic_gibbs_sampler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state.
	bit [23:0] p_alpha = 24'd32768;
	bit [23:0] p_beta = 24'd655;
	bit [6:0]  p_topics = 7'd64;
	bit [14:0] p_vocab = 15'd16384;
	bit        p_fixed = 1'b0;
	bit [31:0] author_topic_cnt [65536];
	bit [31:0] author_total [1024];
	bit [31:0] word_topic_cnt [1048576];
	bit [31:0] topic_total [64];
	bit [9:0]  slot_author [8192];
	bit [15:0] slot_weight [8192];
	bit [3:0]  doc_authors [1024];
	bit [7:0]  slot_written [1024];

	assignment_t pending_q [$];
	token_t      tokens [$];
	int          fails = 0;
	int          cycles = 0;
	bit          no_idle = 1'b0;
	int          hold_req = 0;
	int          stall_left = 0;

	function automatic bit [31:0] add_sat(bit [31:0] x, bit [31:0] y);
		bit [32:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic bit [31:0] dec_sat(bit [31:0] x);
		return (x != 0) ? x - 1 : 0;
	endfunction

	function automatic bit [63:0] fix_div(bit [63:0] n, bit [63:0] d);
		bit [127:0] q;
		if (d == 0)
			return 0;
		q = {32'b0, n, 32'b0} / {64'b0, d};
		return (q[127:64] != 0) ? '1 : q[63:0];
	endfunction

	function automatic bit [63:0] q_mul(bit [63:0] a, bit [63:0] b);
		bit [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return (p[127:96] != 0) ? '1 : p[95:32];
	endfunction

	function automatic bit [63:0] int_mul(bit [63:0] a, bit [63:0] b);
		bit [127:0] p;
		p = {64'b0, a} * {64'b0, b};
		return (p[127:64] != 0) ? '1 : p[63:0];
	endfunction

	function automatic void pair_add(bit [9:0] a, bit [5:0] t, bit [13:0] w);
		author_topic_cnt[{a, t}] = add_sat(author_topic_cnt[{a, t}], 1);
		author_total[a] = add_sat(author_total[a], 1);
		if (!p_fixed) begin
			word_topic_cnt[{w, t}] = add_sat(word_topic_cnt[{w, t}], 1);
			topic_total[t] = add_sat(topic_total[t], 1);
		end
	endfunction

	function automatic void pair_remove(bit [9:0] a, bit [5:0] t, bit [13:0] w);
		author_topic_cnt[{a, t}] = dec_sat(author_topic_cnt[{a, t}]);
		author_total[a] = dec_sat(author_total[a]);
		if (!p_fixed) begin
			word_topic_cnt[{w, t}] = dec_sat(word_topic_cnt[{w, t}]);
			topic_total[t] = dec_sat(topic_total[t]);
		end
	endfunction

	function automatic assignment_t predict_assignment(token_word_t it);
		assignment_t r;
		bit [63:0]   cum [512];
		bit [63:0]   run, w, num_a, den_a, num_w, den_w, thr;
		bit [64:0]   s;
		bit [95:0]   p;
		bit [9:0]    a;
		int          k, nda, idx, n;
		r.author = it.author;
		r.topic = it.topic;
		r.status = 1'b0;
		case (it.action)
			ACT_LOAD_SLOT: begin
				slot_author[{it.doc, it.slot}] = it.author;
				slot_weight[{it.doc, it.slot}] = it.weight;
				doc_authors[it.doc] = (it.slot_count > 8) ? 4'd8 : it.slot_count;
			end
			ACT_ADD_TOKEN: pair_add(it.author, it.topic, it.word);
			ACT_LOAD_WORD: begin
				word_topic_cnt[{it.word, it.topic}] = {1'b0, it.count_value};
				topic_total[it.topic] = add_sat(topic_total[it.topic], {1'b0, it.count_value});
			end
			default: begin
				k = (p_topics < 1) ? 1 : ((p_topics > 64) ? 64 : p_topics);
				nda = doc_authors[it.doc];
				pair_remove(it.author, it.topic, it.word);
				run = 0;
				for (int ai = 0; ai < nda; ai++) begin
					a = slot_author[{it.doc, 3'(ai)}];
					for (int l = 0; l < k; l++) begin
						num_a = ({32'b0, author_topic_cnt[{a, 6'(l)}]} << 16) + p_alpha;
						den_a = ({32'b0, author_total[a]} << 16) + 64'(k) * 64'(p_alpha);
						num_w = ({32'b0, word_topic_cnt[{it.word, 6'(l)}]} << 16) + p_beta;
						den_w = ({32'b0, topic_total[l]} << 16) + 64'(p_vocab) * 64'(p_beta);
						w = 0;
						if (den_a != 0 && den_w != 0)
							w = int_mul(q_mul(fix_div(num_a, den_a), fix_div(num_w, den_w)),
								{48'b0, slot_weight[{it.doc, 3'(ai)}]});
						s = {1'b0, run} + {1'b0, w};
						run = s[64] ? '1 : s[63:0];
						cum[ai * k + l] = run;
					end
				end
				p = {32'b0, run} * {64'b0, it.random_fraction};
				thr = p[95:32];
				n = nda * k;
				for (idx = 0; idx < n; idx++)
					if (cum[idx] > thr)
						break;
				if (idx == n) begin
					r.status = 1'b1;
				end else begin
					r.author = slot_author[{it.doc, 3'(idx / k)}];
					r.topic = 6'(idx % k);
				end
				pair_add(r.author, r.topic, it.word);
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 99)
			return $urandom_range(4, 12);
		return $urandom_range(30, 150);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result checker and receiver stalls.
	always @(posedge clk) begin
		assignment_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_q.size() == 0) begin
				$error("result word with no expectation waiting");
				fails++;
			end else begin
				e = pending_q.pop_front();
				if (m_axis_tdata[9:0] !== e.author) begin
					$error("new_author: expected %0d, got %0d", e.author, m_axis_tdata[9:0]);
					fails++;
				end
				if (m_axis_tdata[15:10] !== e.topic) begin
					$error("new_topic: expected %0d, got %0d", e.topic, m_axis_tdata[15:10]);
					fails++;
				end
				if (m_axis_tuser[0] !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, m_axis_tuser[0]);
					fails++;
				end
			end
		end
		if (hold_req > 0) begin
			hold_req <= hold_req - 1;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!no_idle)
				stall_left <= pick_gap();
		end
	end

	task automatic send_word(input token_word_t it, output assignment_t e);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= it.action;
		s_axis_tdata <= {2'b0, it.random_fraction, it.count_value, it.topic, it.word,
			it.weight, it.author, it.slot_count, it.slot, it.doc};
		do @(posedge clk); while (!s_axis_tready);
		e = predict_assignment(it);
		pending_q.push_back(e);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [23:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_ALPHA:      p_alpha = val;
			CFG_BETA:       p_beta = val;
			CFG_NUM_TOPICS: p_topics = val[6:0];
			CFG_VOCAB_SIZE: p_vocab = val[14:0];
			default:        p_fixed = val[0];
		endcase
	endtask

	task automatic configure(input bit [23:0] a, input bit [23:0] b, input bit [6:0] k,
			input bit [14:0] v, input bit f);
		drain();
		cfg_write(CFG_ALPHA, a);
		cfg_write(CFG_BETA, b);
		cfg_write(CFG_NUM_TOPICS, {17'b0, k});
		cfg_write(CFG_VOCAB_SIZE, {9'b0, v});
		cfg_write(CFG_FIXED_WORD, {23'b0, f});
	endtask

	function automatic token_word_t blank(logic [1:0] act);
		token_word_t it;
		it = '{default: '0};
		it.action = act;
		return it;
	endfunction

	task automatic load_slot(input bit [9:0] doc, input bit [2:0] slot, input bit [3:0] sc,
			input bit [9:0] author, input bit [15:0] wt);
		token_word_t it;
		assignment_t e;
		it = blank(ACT_LOAD_SLOT);
		it.doc = doc;
		it.slot = slot;
		it.slot_count = sc;
		it.author = author;
		it.weight = wt;
		it.word = 14'($urandom);
		it.topic = 6'($urandom);
		it.random_fraction = $urandom;
		slot_written[doc][slot] = 1'b1;
		send_word(it, e);
	endtask

	task automatic resample_word(input bit [9:0] doc, input bit [9:0] author,
			input bit [5:0] topic, input bit [13:0] word, input bit [31:0] rnd,
			output assignment_t e);
		token_word_t it;
		it = blank(ACT_RESAMPLE);
		it.doc = doc;
		it.author = author;
		it.topic = topic;
		it.word = word;
		it.random_fraction = rnd;
		send_word(it, e);
	endtask

	function automatic bit [31:0] rand_fraction();
		int r;
		r = $urandom_range(0, 9);
		return (r == 0) ? 32'h0 : ((r == 1) ? 32'hFFFF_FFFF : $urandom);
	endfunction

	function automatic bit [9:0] rand_author();
		return ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
	endfunction

	task automatic test_directed_extremes();
		token_word_t it;
		assignment_t e;
		for (int s = 0; s < 8; s++)
			load_slot(10'd0, 3'(s), 4'd8, (s == 0) ? 10'd1023 : 10'(s - 1),
				s[0] ? 16'd0 : 16'hFFFF);
		it = blank(ACT_ADD_TOKEN);
		it.doc = 10'd0;
		it.author = 10'd1023;
		it.topic = 6'd63;
		it.word = 14'd16383;
		send_word(it, e);
		it = blank(ACT_LOAD_WORD);
		it.word = 14'd16383;
		it.topic = 6'd63;
		it.count_value = 31'h7FFF_FFFF;
		send_word(it, e);
		it = blank(ACT_LOAD_WORD);
		it.word = 14'd0;
		it.topic = 6'd0;
		it.count_value = 31'h7FFF_FFFF;
		send_word(it, e);
		resample_word(10'd0, 10'd1023, 6'd63, 14'd16383, 32'hFFFF_FFFF, e);
		// A document without authors, and a token that was never added.
		resample_word(10'd5, 10'd3, 6'd1, 14'd2, 32'h0, e);
		// A slot count above the limit is stored as eight.
		load_slot(10'd0, 3'd7, 4'd15, 10'd512, 16'd1);
		load_slot(10'd1, 3'd0, 4'd1, 10'd7, 16'd100);
	endtask

	task automatic test_config_extremes();
		token_word_t it;
		assignment_t e;
		configure(24'd0, 24'd0, 7'd0, 15'd1, 1'b1);
		resample_word(10'd0, 10'd0, 6'd0, 14'd0, 32'h8000_0000, e);
		it = blank(ACT_ADD_TOKEN);
		it.doc = 10'd1;
		it.author = 10'd7;
		it.topic = 6'd0;
		it.word = 14'd9;
		send_word(it, e);
		resample_word(10'd1, 10'd7, 6'd0, 14'd9, 32'h0, e);
		configure(24'hFF_FFFF, 24'hFF_FFFF, 7'd127, 15'd32767, 1'b0);
		resample_word(10'd1, 10'd7, 6'd0, 14'd9, 32'hFFFF_FFFF, e);
		resample_word(10'd1, 10'd7, 6'd0, 14'd9, 32'h4000_0000, e);
	endtask

	task automatic send_random(input int n_items);
		token_word_t it;
		assignment_t e;
		token_t      tk;
		int          sent, choice, na, k, ti, m;
		bit [9:0]    doc;
		sent = 0;
		k = (p_topics < 1) ? 1 : ((p_topics > 64) ? 64 : p_topics);
		while (sent < n_items) begin
			choice = $urandom_range(0, 99);
			if (choice < 12) begin
				doc = 10'($urandom);
				na = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(1, 8);
				for (int s = 0; s < na; s++) begin
					load_slot(doc, 3'(s), 4'(na), rand_author(),
						($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom));
					sent++;
				end
			end else if (choice < 38) begin
				it = blank(ACT_ADD_TOKEN);
				it.doc = 10'($urandom);
				it.author = rand_author();
				it.topic = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, k - 1));
				it.word = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 31));
				it.random_fraction = $urandom;
				send_word(it, e);
				tokens.push_back('{it.doc, it.author, it.topic, it.word});
				sent++;
			end else if (choice < 80) begin
				if (tokens.size() != 0 && $urandom_range(0, 9) != 0) begin
					ti = $urandom_range(0, tokens.size() - 1);
					tk = tokens[ti];
					if ($urandom_range(0, 1) == 0)
						tk.doc = 10'($urandom);
					resample_word(tk.doc, tk.author, tk.topic, tk.word, rand_fraction(), e);
					tokens[ti].author = e.author;
					tokens[ti].topic = e.topic;
				end else begin
					resample_word(10'($urandom), rand_author(), 6'($urandom), 14'($urandom),
						rand_fraction(), e);
				end
				sent++;
			end else if (choice < 90) begin
				it = blank(ACT_LOAD_WORD);
				it.word = ($urandom_range(0, 1) == 0) ? 14'($urandom) : 14'($urandom_range(0, 31));
				it.topic = 6'($urandom_range(0, k - 1));
				it.count_value = ($urandom_range(0, 1) == 0) ? 31'($urandom_range(0, 20))
					: 31'($urandom);
				it.doc = 10'($urandom);
				send_word(it, e);
				sent++;
			end else begin
				it.action = 2'($urandom);
				it.doc = 10'($urandom);
				it.slot = 3'($urandom);
				it.author = 10'($urandom);
				it.weight = 16'($urandom);
				it.word = 14'($urandom);
				it.topic = 6'($urandom);
				it.count_value = 31'($urandom);
				it.random_fraction = $urandom;
				if (it.action == ACT_LOAD_SLOT) begin
					// Keep the author count within the slots written so far.
					slot_written[it.doc][it.slot] = 1'b1;
					m = 0;
					while (m < 8 && slot_written[it.doc][m])
						m++;
					it.slot_count = (m == 8) ? 4'($urandom) : 4'($urandom_range(0, m));
				end else begin
					it.slot_count = 4'($urandom);
				end
				send_word(it, e);
				sent++;
			end
		end
	endtask

	task automatic test_backpressure();
		token_word_t it;
		assignment_t e;
		drain();
		no_idle = 1'b1;
		hold_req = 3000;
		for (int i = 0; i < 12; i++) begin
			it = blank(ACT_ADD_TOKEN);
			it.author = rand_author();
			it.topic = 6'($urandom);
			it.word = 14'($urandom);
			send_word(it, e);
		end
		drain();
		no_idle = 1'b0;
	endtask

	task automatic test_paused_sender();
		send_random(20);
		drain();
		repeat ($urandom_range(5, 60)) @(posedge clk);
		send_random(20);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_extremes();
		test_config_extremes();
		configure(24'd32768, 24'd655, 7'd4, 15'd16384, 1'b0);
		send_random(190);
		test_backpressure();
		configure(24'hFF_FFFF, 24'hFF_FFFF, 7'd3, 15'd1, 1'b0);
		no_idle = 1'b1;
		send_random(160);
		no_idle = 1'b0;
		configure(24'd1000, 24'd20, 7'd2, 15'd32767, 1'b1);
		send_random(170);
		configure(24'd0, 24'd0, 7'd1, 15'd16384, 1'b0);
		send_random(150);
		configure(24'd65536, 24'd1, 7'd64, 15'd100, 1'b0);
		send_random(6);
		configure(24'd12345, 24'd6553, 7'd4, 15'd5000, 1'b1);
		test_paused_sender();
		send_random(250);
		drain();
		repeat (100) @(posedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

[author_topic_gibbs_sampler_unit.f]
+incdir+rtl
rtl/atgs_pkg.sv
rtl/atgs_div.sv
rtl/atgs_ctrl.sv
rtl/atgs_dp.sv
rtl/author_topic_gibbs_sampler_unit.sv
bench/tb_author_topic_gibbs_sampler_unit.sv
